### hdl/lfds_pkg.sv
// Shared types and constants for the LED frame delta sender.
package lfds_pkg;

  localparam int LFDS_LEDS = 64;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_INIT  = 2'd3;

  localparam logic [7:0] IDX_FLAG     = 8'h80;
  localparam logic [7:0] REPAINT_BYTE = 8'h40;
  localparam logic [7:0] RESET_BYTE   = 8'hFF;

  localparam logic [4:0] MAX_PAIRS_RST = 5'd31;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] led_index;
    logic [7:0] color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

endpackage

### hdl/lfds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfds_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                            wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                            rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/led_frame_delta_sender.sv
// Top level of the LED frame delta sender: control, valid bits and two frame RAMs.
//
// The block keeps the current LED frame and a shadow of the frame last sent,
// one color byte per LED, in two RAMs. Set writes one LED in the cycle it is
// accepted (indexes at or above LEDS are dropped); fill sweeps all LEDS
// entries, one write per cycle. Flush scans the LEDs from index 0, reading
// both RAMs at the same address each cycle until a change is found; the read
// and the compare overlap. Each changed LED emits two items (index with bit 7
// set, then the color) and updates the shadow; the scan resumes after the
// pair and reissues the read it dropped. The scan stops after max_pairs pairs
// (zero acts as one), and a flush that sent any pair ends with 0x40 marked last.
// Init clears both frames at once through per-entry valid bits and emits 0xFF
// marked last. Output items are held in one register, so a stalled consumer
// only stalls the emit steps; a new item is taken once the current one has
// handed off its last result to that register. max_pairs is written through
// cfg_we/cfg_wdata and resets to 31.
module led_frame_delta_sender #(
  parameter int LEDS = lfds_pkg::LFDS_LEDS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lfds_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lfds_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [4:0]           cfg_wdata
);

  localparam int AW = (LEDS > 1) ? $clog2(LEDS) : 1;
  localparam int CW = $clog2(LEDS + 1);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_FILL     = 7'b0000010,
    ST_SCAN     = 7'b0000100,
    ST_EMIT_IDX = 7'b0001000,
    ST_EMIT_COL = 7'b0010000,
    ST_EMIT_REP = 7'b0100000,
    ST_EMIT_RST = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [4:0]          max_pairs_r;
  logic [4:0]          limit;
  logic [4:0]          pairs_r, pairs_nxt;
  logic [CW-1:0]       scan_r, scan_nxt;
  logic [AW-1:0]       cmp_addr_r, cmp_addr_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       fill_r, fill_nxt;
  logic [7:0]          color_r, color_nxt;
  logic [LEDS-1:0]     now_vld_r, sent_vld_r;
  logic                now_vq_r, sent_vq_r;
  logic                out_valid_r;
  lfds_pkg::out_item_t out_data_r;

  // RAM ports
  logic                now_we, sent_we, rd_en;
  logic [AW-1:0]       now_waddr, rd_addr;
  logic [7:0]          now_wdata, now_q, sent_q;
  logic [7:0]          now_v, sent_v;

  logic                in_acc, out_free, out_load, clr_all, mismatch;
  lfds_pkg::out_item_t out_item_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign limit   = (max_pairs_r == 5'd0) ? 5'd1 : max_pairs_r;
  assign rd_addr = scan_r[AW-1:0];

  // Entries never written since reset or init read as zero.
  assign now_v    = now_vq_r  ? now_q  : 8'h00;
  assign sent_v   = sent_vq_r ? sent_q : 8'h00;
  assign mismatch = pend_r && (now_v != sent_v);

  lfds_ram #(.W(8), .DEPTH(LEDS)) u_now_ram (
    .clk   (clk),
    .we    (now_we),
    .waddr (now_waddr),
    .wdata (now_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (now_q)
  );

  lfds_ram #(.W(8), .DEPTH(LEDS)) u_sent_ram (
    .clk   (clk),
    .we    (sent_we),
    .waddr (cmp_addr_r),
    .wdata (now_v),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (sent_q)
  );

  always_comb begin
    state_nxt    = state_r;
    pairs_nxt    = pairs_r;
    scan_nxt     = scan_r;
    cmp_addr_nxt = cmp_addr_r;
    pend_nxt     = pend_r;
    fill_nxt     = fill_r;
    color_nxt    = color_r;
    now_we       = 1'b0;
    now_waddr    = fill_r;
    now_wdata    = color_r;
    sent_we      = 1'b0;
    rd_en        = 1'b0;
    clr_all      = 1'b0;
    out_load     = 1'b0;
    out_item_nxt = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data.opcode)
            lfds_pkg::OP_SET: begin
              if (9'(in_data.led_index) < 9'(LEDS)) begin
                now_we    = 1'b1;
                now_waddr = in_data.led_index[AW-1:0];
                now_wdata = in_data.color;
              end
            end
            lfds_pkg::OP_FILL: begin
              color_nxt = in_data.color;
              fill_nxt  = '0;
              state_nxt = ST_FILL;
            end
            lfds_pkg::OP_FLUSH: begin
              scan_nxt  = '0;
              pend_nxt  = 1'b0;
              pairs_nxt = '0;
              state_nxt = ST_SCAN;
            end
            lfds_pkg::OP_INIT: begin
              clr_all   = 1'b1;
              state_nxt = ST_EMIT_RST;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        now_we   = 1'b1;
        fill_nxt = fill_r + AW'(1);
        if (fill_r == AW'(LEDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (mismatch) begin
          // update shadow now; no read is issued this cycle and the scan address is held
          sent_we   = 1'b1;
          color_nxt = now_v;
          pend_nxt  = 1'b0;
          state_nxt = ST_EMIT_IDX;
        end else if (scan_r < CW'(LEDS)) begin
          rd_en        = 1'b1;
          cmp_addr_nxt = scan_r[AW-1:0];
          pend_nxt     = 1'b1;
          scan_nxt     = scan_r + CW'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = (pairs_r != 5'd0) ? ST_EMIT_REP : ST_IDLE;
        end
      end
      ST_EMIT_IDX: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_item_nxt.out_byte  = lfds_pkg::IDX_FLAG | 8'(cmp_addr_r);
          out_item_nxt.last_byte = 1'b0;
          state_nxt              = ST_EMIT_COL;
        end
      end
      ST_EMIT_COL: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_item_nxt.out_byte  = color_r;
          out_item_nxt.last_byte = 1'b0;
          pairs_nxt              = pairs_r + 5'd1;
          state_nxt = (pairs_nxt == limit) ? ST_EMIT_REP : ST_SCAN;
        end
      end
      ST_EMIT_REP: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_item_nxt.out_byte  = lfds_pkg::REPAINT_BYTE;
          out_item_nxt.last_byte = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      ST_EMIT_RST: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_item_nxt.out_byte  = lfds_pkg::RESET_BYTE;
          out_item_nxt.last_byte = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_pairs_r <= lfds_pkg::MAX_PAIRS_RST;
      pend_r      <= 1'b0;
      pairs_r     <= '0;
      scan_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      now_vld_r   <= '0;
      sent_vld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      pairs_r <= pairs_nxt;
      scan_r  <= scan_nxt;
      fill_r  <= fill_nxt;
      if (cfg_we) begin
        max_pairs_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (clr_all) begin
        now_vld_r  <= '0;
        sent_vld_r <= '0;
      end else begin
        if (now_we) begin
          now_vld_r[now_waddr] <= 1'b1;
        end
        if (sent_we) begin
          sent_vld_r[cmp_addr_r] <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmp_addr_r <= cmp_addr_nxt;
    color_r    <= color_nxt;
    if (rd_en) begin
      now_vq_r  <= now_vld_r[rd_addr];
      sent_vq_r <= sent_vld_r[rd_addr];
    end
    if (out_load) begin
      out_data_r <= out_item_nxt;
    end
  end

  // pair count never runs past the limit while a flush is running
  a_pairs_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_EMIT_IDX ||
     state_r == ST_EMIT_COL || state_r == ST_EMIT_REP) |-> (pairs_r <= limit))
    else $error("pair count beyond max_pairs");

  // a detected change always goes out as an index item next
  a_mismatch_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && mismatch) |=> (state_r == ST_EMIT_IDX))
    else $error("changed LED not emitted");

  // repaint item is the last item of the flush
  a_repaint_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_REP && out_free) |=>
      (out_valid_r && out_data_r.last_byte &&
       out_data_r.out_byte == lfds_pkg::REPAINT_BYTE))
    else $error("repaint item wrong");

  // init clears both frames at once
  a_init_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.opcode == lfds_pkg::OP_INIT) |=>
      (now_vld_r == '0 && sent_vld_r == '0))
    else $error("init did not clear frames");

endmodule
